// ===== hdl/tbvt_pkg.sv =====
// Package for the tagged binary value tokenizer.
// Holds the token and error codes, the per-byte class record and the type decoders.
// No dependencies.
`timescale 1ns / 1ps

package tbvt_pkg;

	localparam int CountWidth = 32;
	localparam int QueueDepth = 2;
	localparam int QueuePtrWidth = $clog2(QueueDepth);
	localparam int QueueCntWidth = $clog2(QueueDepth + 1);

	localparam logic [7:0] TypeNil = 8'd0;
	localparam logic [7:0] TypeString = 8'd16;
	localparam logic [7:0] PrefixOpen = 8'h80;
	localparam logic [7:0] PrefixClose = 8'h81;
	localparam logic [7:0] TypeMask = 8'h7F;

	localparam logic [7:0] TypeI16Le = 8'd1;
	localparam logic [7:0] TypeI32Le = 8'd2;
	localparam logic [7:0] TypeI64Le = 8'd13;
	localparam logic [7:0] TypeI16Be = 8'd9;
	localparam logic [7:0] TypeI32Be = 8'd10;
	localparam logic [7:0] TypeI64Be = 8'd14;

	localparam logic [63:0] CountMax = {64{1'b1}} >> (64 - CountWidth);

	typedef enum logic [2:0] {
		KIND_INT   = 3'd0,
		KIND_STR   = 3'd1,
		KIND_EMPTY = 3'd2,
		KIND_NIL   = 3'd3,
		KIND_ERR   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ERR_BAD_INT    = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_NO_CLOSE   = 2'd2,
		ERR_NEG_COUNT  = 2'd3
	} err_t;

	// Class of one stream byte. The integer size and order are those of the
	// byte with bit 7 masked off; the plain type has size zero when bit 7 is set.
	typedef struct packed {
		logic [7:0] data;
		logic       is_nil;
		logic       is_str;
		logic       is_open;
		logic       is_close;
		logic [3:0] msize;
		logic       mlittle;
	} class_t;

	function automatic logic [3:0] int_size(input logic [7:0] t);
		logic [3:0] s;
		s = 4'd0;
		if (t == TypeI16Le || t == TypeI16Be) s = 4'd2;
		if (t == TypeI32Le || t == TypeI32Be) s = 4'd4;
		if (t == TypeI64Le || t == TypeI64Be) s = 4'd8;
		return s;
	endfunction

	function automatic logic is_little(input logic [7:0] t);
		return (t == TypeI16Le) || (t == TypeI32Le) || (t == TypeI64Le);
	endfunction

endpackage

// ===== hdl/tbvt_front.sv =====
// Front end of the tokenizer: accepts stream bytes and classifies them.
// Depends on tbvt_pkg; feeds tbvt_queue.
`timescale 1ns / 1ps

module tbvt_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  q_full,
	output logic                  push,
	output tbvt_pkg::class_t      push_cls
);

	logic [7:0] masked;

	assign masked = data_byte & tbvt_pkg::TypeMask;
	assign in_ready = !q_full;
	assign push = in_valid && !q_full;

	always_comb begin
		push_cls.data     = data_byte;
		push_cls.is_nil   = (data_byte == tbvt_pkg::TypeNil);
		push_cls.is_str   = (data_byte == tbvt_pkg::TypeString);
		push_cls.is_open  = (data_byte == tbvt_pkg::PrefixOpen);
		push_cls.is_close = (data_byte == tbvt_pkg::PrefixClose);
		push_cls.msize    = tbvt_pkg::int_size(masked);
		push_cls.mlittle  = tbvt_pkg::is_little(masked);
	end

endmodule

// ===== hdl/tbvt_queue.sv =====
// Short queue of classified bytes between the front and back ends.
// Depends on tbvt_pkg.
`timescale 1ns / 1ps

module tbvt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tbvt_pkg::class_t push_cls,
	output logic             full,
	input  logic             pop,
	output logic             q_valid,
	output tbvt_pkg::class_t q_cls
);

	tbvt_pkg::class_t mem_q [tbvt_pkg::QueueDepth];
	logic [tbvt_pkg::QueuePtrWidth-1:0] wptr_q;
	logic [tbvt_pkg::QueuePtrWidth-1:0] rptr_q;
	logic [tbvt_pkg::QueueCntWidth-1:0] cnt_q;

	assign full = (cnt_q == tbvt_pkg::QueueCntWidth'(tbvt_pkg::QueueDepth));
	assign q_valid = (cnt_q != '0);
	assign q_cls = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == tbvt_pkg::QueuePtrWidth'(tbvt_pkg::QueueDepth - 1))
					? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == tbvt_pkg::QueuePtrWidth'(tbvt_pkg::QueueDepth - 1))
					? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/tbvt_back.sv =====
// Back end of the tokenizer: parse state machine and the output token register.
// Depends on tbvt_pkg; reads classified bytes from tbvt_queue.
`timescale 1ns / 1ps

module tbvt_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  tbvt_pkg::class_t                    q_cls,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [2:0]                          token_kind,
	output logic signed [63:0]                  token_value,
	output logic                                last_of_string,
	output logic [1:0]                          error_code
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_PREFIX_TYPE,
		PH_PREFIX_CLOSE,
		PH_INT,
		PH_COUNT,
		PH_STRING
	} phase_t;

	phase_t                              phase_q, phase_d;
	tbvt_pkg::class_t                    pend_q, pend_d;
	logic [3:0]                          size_q, size_d;
	logic                                little_q, little_d;
	logic [3:0]                          left_q, left_d;
	logic [63:0]                         acc_q, acc_d;
	logic                                is_count_q, is_count_d;
	logic [tbvt_pkg::CountWidth-1:0]     str_left_q, str_left_d;
	logic                                halted_q, halted_d;

	logic                                out_valid_q;
	tbvt_pkg::kind_t                     kind_q, kind_d;
	logic [63:0]                         value_q, value_d;
	logic                                last_q, last_d;
	tbvt_pkg::err_t                      code_q, code_d;
	logic                                emit_d;

	logic [7:0]                          b;
	logic [3:0]                          psize;
	logic [2:0]                          taken;
	logic [63:0]                         acc_nx;
	logic [63:0]                         ival;
	logic [tbvt_pkg::CountWidth-1:0]     ilen;

	assign pop = q_valid && (!out_valid_q || out_ready);
	assign b = q_cls.data;
	assign psize = pend_q.data[7] ? 4'd0 : pend_q.msize;
	assign taken = 3'(size_q - left_q);
	assign acc_nx = little_q ? (acc_q | (64'(b) << {taken, 3'b000})) : {acc_q[55:0], b};
	assign ilen = (ival > tbvt_pkg::CountMax) ? {tbvt_pkg::CountWidth{1'b1}}
		: ival[tbvt_pkg::CountWidth-1:0];

	always_comb begin
		unique case (size_q)
			4'd2: ival = {{48{acc_nx[15]}}, acc_nx[15:0]};
			4'd4: ival = {{32{acc_nx[31]}}, acc_nx[31:0]};
			default: ival = acc_nx;
		endcase
	end

	always_comb begin
		logic       disp;
		logic       d_nil;
		logic       d_str;
		logic [3:0] d_size;
		logic       d_little;

		phase_d    = phase_q;
		pend_d     = pend_q;
		size_d     = size_q;
		little_d   = little_q;
		left_d     = left_q;
		acc_d      = acc_q;
		is_count_d = is_count_q;
		str_left_d = str_left_q;
		halted_d   = halted_q;
		emit_d     = 1'b0;
		kind_d     = tbvt_pkg::KIND_NIL;
		value_d    = '0;
		last_d     = 1'b0;
		code_d     = tbvt_pkg::ERR_BAD_INT;
		disp       = 1'b0;
		d_nil      = q_cls.is_nil;
		d_str      = q_cls.is_str;
		d_size     = q_cls.data[7] ? 4'd0 : q_cls.msize;
		d_little   = q_cls.mlittle;

		if (!halted_q) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (q_cls.is_open) begin
						phase_d = PH_PREFIX_TYPE;
					end else begin
						disp = 1'b1;
					end
				end
				PH_PREFIX_TYPE: begin
					pend_d  = q_cls;
					phase_d = PH_PREFIX_CLOSE;
				end
				PH_PREFIX_CLOSE: begin
					if (!q_cls.is_close) begin
						emit_d   = 1'b1;
						kind_d   = tbvt_pkg::KIND_ERR;
						code_d   = tbvt_pkg::ERR_NO_CLOSE;
						halted_d = 1'b1;
						phase_d  = PH_TYPE;
					end else begin
						disp     = 1'b1;
						d_nil    = pend_q.is_nil;
						d_str    = pend_q.is_str;
						d_size   = psize;
						d_little = pend_q.mlittle;
					end
				end
				PH_COUNT: begin
					if (!b[7]) begin
						if (b == 8'd0) begin
							emit_d  = 1'b1;
							kind_d  = tbvt_pkg::KIND_EMPTY;
							phase_d = PH_TYPE;
						end else begin
							str_left_d = tbvt_pkg::CountWidth'(b);
							phase_d    = PH_STRING;
						end
					end else if (q_cls.msize == 4'd0) begin
						emit_d   = 1'b1;
						kind_d   = tbvt_pkg::KIND_ERR;
						code_d   = tbvt_pkg::ERR_BAD_INT;
						halted_d = 1'b1;
						phase_d  = PH_TYPE;
					end else begin
						size_d     = q_cls.msize;
						little_d   = q_cls.mlittle;
						left_d     = q_cls.msize;
						acc_d      = '0;
						is_count_d = 1'b1;
						phase_d    = PH_INT;
					end
				end
				PH_INT: begin
					acc_d  = acc_nx;
					left_d = left_q - 1'b1;
					if (left_q == 4'd1) begin
						if (!is_count_q) begin
							emit_d  = 1'b1;
							kind_d  = tbvt_pkg::KIND_INT;
							value_d = ival;
							phase_d = PH_TYPE;
						end else if (ival[63]) begin
							emit_d   = 1'b1;
							kind_d   = tbvt_pkg::KIND_ERR;
							code_d   = tbvt_pkg::ERR_NEG_COUNT;
							halted_d = 1'b1;
							phase_d  = PH_TYPE;
						end else if (ival == 64'd0) begin
							emit_d  = 1'b1;
							kind_d  = tbvt_pkg::KIND_EMPTY;
							phase_d = PH_TYPE;
						end else begin
							str_left_d = ilen;
							phase_d    = PH_STRING;
						end
					end
				end
				PH_STRING: begin
					emit_d     = 1'b1;
					kind_d     = tbvt_pkg::KIND_STR;
					value_d    = 64'(b);
					last_d     = (str_left_q == tbvt_pkg::CountWidth'(1));
					str_left_d = str_left_q - 1'b1;
					if (str_left_q == tbvt_pkg::CountWidth'(1)) begin
						phase_d = PH_TYPE;
					end
				end
				default: begin
					phase_d = PH_TYPE;
				end
			endcase

			if (disp) begin
				priority if (d_nil) begin
					emit_d  = 1'b1;
					kind_d  = tbvt_pkg::KIND_NIL;
					phase_d = PH_TYPE;
				end else if (d_str) begin
					phase_d = PH_COUNT;
				end else if (d_size != 4'd0) begin
					size_d     = d_size;
					little_d   = d_little;
					left_d     = d_size;
					acc_d      = '0;
					is_count_d = 1'b0;
					phase_d    = PH_INT;
				end else begin
					emit_d   = 1'b1;
					kind_d   = tbvt_pkg::KIND_ERR;
					code_d   = tbvt_pkg::ERR_UNEXPECTED;
					halted_d = 1'b1;
					phase_d  = PH_TYPE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TYPE;
			pend_q      <= '0;
			size_q      <= '0;
			little_q    <= 1'b0;
			left_q      <= '0;
			acc_q       <= '0;
			is_count_q  <= 1'b0;
			str_left_q  <= '0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
			kind_q      <= tbvt_pkg::KIND_NIL;
			value_q     <= '0;
			last_q      <= 1'b0;
			code_q      <= tbvt_pkg::ERR_BAD_INT;
		end else begin
			if (pop) begin
				phase_q    <= phase_d;
				pend_q     <= pend_d;
				size_q     <= size_d;
				little_q   <= little_d;
				left_q     <= left_d;
				acc_q      <= acc_d;
				is_count_q <= is_count_d;
				str_left_q <= str_left_d;
				halted_q   <= halted_d;
			end
			if (pop && emit_d) begin
				out_valid_q <= 1'b1;
				kind_q      <= kind_d;
				value_q     <= value_d;
				last_q      <= last_d;
				code_q      <= code_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign token_kind     = kind_q;
	assign token_value    = value_q;
	assign last_of_string = last_q;
	assign error_code     = code_q;

endmodule

// ===== hdl/tagged_binary_value_tokenizer.sv =====
// Top level of the tagged binary value tokenizer.
// Depends on tbvt_pkg, tbvt_front, tbvt_queue and tbvt_back.
`timescale 1ns / 1ps

// The block reads a tagged binary stream one byte per word on the input channel
// (in_valid, in_ready, data_byte) and returns tokens on the output channel
// (out_valid, out_ready, token_kind, token_value, last_of_string, error_code).
// Each token is an integer, one string byte, an empty string, a nil or an error.
// Bytes that only advance the parse (type bytes, prefixes, count and integer
// bytes before the last) give no token.
// The front end classifies each byte and writes it to a two-entry queue; the
// back end runs the parse state machine and holds one token in its output
// register. The token of a byte passes through the queue and the output register.
// One byte is taken per cycle as long as the receiver takes tokens; the rate is
// set by the single state update per byte in the back end.
// When the receiver stalls, the token waits in the output register, the queue
// fills and then in_ready falls; nothing is dropped.
// An error token halts the block: later bytes are still accepted but give no
// tokens. Reset clears the queue, the parse state, the halt and the output.

module tagged_binary_value_tokenizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         token_kind,
	output logic signed [63:0] token_value,
	output logic               last_of_string,
	output logic [1:0]         error_code
);

	logic             push;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	tbvt_pkg::class_t push_cls;
	tbvt_pkg::class_t q_cls;

	tbvt_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.q_full   (q_full),
		.push     (push),
		.push_cls (push_cls)
	);

	tbvt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cls(push_cls),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_cls   (q_cls)
	);

	tbvt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cls         (q_cls),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_kind    (token_kind),
		.token_value   (token_value),
		.last_of_string(last_of_string),
		.error_code    (error_code)
	);

endmodule

// ===== hdl/tbvt_checker.sv =====
// Port-level checker for the tagged binary value tokenizer, with its bind.
// Depends on tbvt_pkg and the top level tagged_binary_value_tokenizer.
`timescale 1ns / 1ps

module tbvt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [2:0]         token_kind,
	input logic signed [63:0] token_value,
	input logic               last_of_string,
	input logic [1:0]         error_code
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_value) && $stable(token_kind))
	else $error("Stalled token changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != tbvt_pkg::KIND_ERR |-> error_code == 2'd0)
	else $error("Error code set on a token that is not an error.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_string |-> token_kind == tbvt_pkg::KIND_STR)
	else $error("Last mark on a token that is not a string byte.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == tbvt_pkg::KIND_NIL || token_kind == tbvt_pkg::KIND_EMPTY
		|| token_kind == tbvt_pkg::KIND_ERR) |-> token_value == 64'sd0)
	else $error("Nonzero value on a token that carries none.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && token_kind == tbvt_pkg::KIND_ERR |=> !out_valid)
	else $error("Token produced after an error.");

endmodule

bind tagged_binary_value_tokenizer tbvt_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.token_kind    (token_kind),
	.token_value   (token_value),
	.last_of_string(last_of_string),
	.error_code    (error_code)
);

// ===== tb/tbvt_token_checker.sv =====
// Token checker for the tagged binary value tokenizer: predicts the token of each accepted
// word and compares the tokens that the block returns, in order.
// Depends on tbvt_pkg.
`timescale 1ns / 1ps

module tbvt_token_checker
	import tbvt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         token_kind,
	input  logic signed [63:0] token_value,
	input  logic               last_of_string,
	input  logic [1:0]         error_code,
	output int                 mismatches,
	output int                 tokens_pending
);

	localparam int ReportLimit = 100;
	// Tokens that are not errors carry a zero error code.
	localparam err_t NoErrorCode = ERR_BAD_INT;

	typedef enum logic [2:0] {
		AWAIT_TYPE,
		AWAIT_TAGGED_TYPE,
		AWAIT_CLOSE,
		AWAIT_COUNT,
		IN_INTEGER,
		IN_STRING
	} stage_t;

	typedef struct {
		kind_t       kind;
		logic [63:0] value;
		logic        last;
		err_t        code;
	} token_t;

	token_t expected_tokens[$];

	stage_t      stage = AWAIT_TYPE;
	logic [7:0]  int_type = '0;
	int          int_left = 0;
	logic [63:0] int_acc = '0;
	bit          int_for_count = 1'b0;
	logic [63:0] string_left = '0;
	bit          stopped = 1'b0;

	function automatic int byte_width(logic [7:0] t);
		case (t)
			TypeI16Le, TypeI16Be: return 2;
			TypeI32Le, TypeI32Be: return 4;
			TypeI64Le, TypeI64Be: return 8;
			default: return 0;
		endcase
	endfunction

	function automatic void expect_token(kind_t k, logic [63:0] v, logic l, err_t e);
		token_t t;
		t.kind = k;
		t.value = v;
		t.last = l;
		t.code = e;
		expected_tokens.push_back(t);
	endfunction

	function automatic void halt_on(err_t e);
		stopped = 1'b1;
		stage = AWAIT_TYPE;
		expect_token(KIND_ERR, '0, 1'b0, e);
	endfunction

	function automatic void open_string(logic [63:0] n);
		if (n == 0) begin
			stage = AWAIT_TYPE;
			expect_token(KIND_EMPTY, '0, 1'b0, NoErrorCode);
		end else begin
			string_left = n;
			stage = IN_STRING;
		end
	endfunction

	function automatic void start_integer(logic [7:0] t, bit for_count);
		int_type = t;
		int_left = byte_width(t);
		int_acc = '0;
		int_for_count = for_count;
		stage = IN_INTEGER;
	endfunction

	function automatic void take_type(logic [7:0] t);
		if (t == TypeNil) begin
			stage = AWAIT_TYPE;
			expect_token(KIND_NIL, '0, 1'b0, NoErrorCode);
		end else if (t == TypeString)
			stage = AWAIT_COUNT;
		else if (byte_width(t) != 0)
			start_integer(t, 1'b0);
		else
			halt_on(ERR_UNEXPECTED);
	endfunction

	function automatic void parse_byte(logic [7:0] b);
		int          size;
		int          taken;
		logic [63:0] v;
		if (stopped)
			return;
		case (stage)
			AWAIT_TAGGED_TYPE: begin
				int_type = b;
				stage = AWAIT_CLOSE;
			end
			AWAIT_CLOSE: begin
				if (b != PrefixClose)
					halt_on(ERR_NO_CLOSE);
				else
					take_type(int_type);
			end
			AWAIT_COUNT: begin
				if (!b[7])
					open_string(64'(b));
				else if (byte_width(b & TypeMask) == 0)
					halt_on(ERR_BAD_INT);
				else
					start_integer(b & TypeMask, 1'b1);
			end
			IN_INTEGER: begin
				size = byte_width(int_type);
				taken = size - int_left;
				if (int_type == TypeI16Le || int_type == TypeI32Le || int_type == TypeI64Le)
					int_acc = int_acc | (64'(b) << (8 * taken));
				else
					int_acc = (int_acc << 8) | 64'(b);
				int_left--;
				if (int_left == 0) begin
					case (size)
						2: v = {{48{int_acc[15]}}, int_acc[15:0]};
						4: v = {{32{int_acc[31]}}, int_acc[31:0]};
						default: v = int_acc;
					endcase
					if (!int_for_count) begin
						stage = AWAIT_TYPE;
						expect_token(KIND_INT, v, 1'b0, NoErrorCode);
					end else if (v[63])
						halt_on(ERR_NEG_COUNT);
					else
						open_string((v > CountMax) ? CountMax : v);
				end
			end
			IN_STRING: begin
				expect_token(KIND_STR, 64'(b), string_left <= 1, NoErrorCode);
				if (string_left != 0)
					string_left--;
				if (string_left == 0)
					stage = AWAIT_TYPE;
			end
			default: begin
				if (b == PrefixOpen)
					stage = AWAIT_TAGGED_TYPE;
				else
					take_type(b);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			if (mismatches < ReportLimit)
				$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			expected_tokens.delete();
			stage = AWAIT_TYPE;
			int_type = '0;
			int_left = 0;
			int_acc = '0;
			int_for_count = 1'b0;
			string_left = '0;
			stopped = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					if (mismatches < ReportLimit)
						$display("%0t: expected no token, got kind %0d value 0x%0h", $time,
							token_kind, token_value);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", want.kind, token_kind);
					check_field("token_value", want.value, token_value);
					check_field("last_of_string", want.last, last_of_string);
					check_field("error_code", want.code, error_code);
				end
			end
			if (in_valid && in_ready)
				parse_byte(data_byte);
		end
		tokens_pending = expected_tokens.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the tagged binary value tokenizer: builds the byte stream,
// drives it in bursts, stalls the token side and gives the verdict.
// Depends on tbvt_pkg, tbvt_token_checker and the tagged_binary_value_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
	import tbvt_pkg::*;

	localparam int StreamTarget = 1900;
	localparam int HoldOffCycles = 250;
	localparam int IdleLimit = 2000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         token_kind;
	logic signed [63:0] token_value;
	logic               last_of_string;
	logic [1:0]         error_code;
	int                 mismatches;
	int                 tokens_pending;
	int                 idle_cycles = 0;
	logic [7:0]         stream_bytes[$];

	tagged_binary_value_tokenizer uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.token_value(token_value),
		.last_of_string(last_of_string),
		.error_code(error_code)
	);

	tbvt_token_checker token_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.token_kind(token_kind),
		.token_value(token_value),
		.last_of_string(last_of_string),
		.error_code(error_code),
		.mismatches(mismatches),
		.tokens_pending(tokens_pending)
	);

	function automatic logic [7:0] int_type_at(int i);
		case (i)
			0: return TypeI16Le;
			1: return TypeI16Be;
			2: return TypeI32Le;
			3: return TypeI32Be;
			4: return TypeI64Le;
			default: return TypeI64Be;
		endcase
	endfunction

	function automatic logic [6:0] non_int_type();
		logic [6:0] t;
		do
			t = 7'($urandom);
		while (int_size({1'b0, t}) != 0);
		return t;
	endfunction

	function automatic void put_header(logic [7:0] t, bit tagged_item);
		if (tagged_item) begin
			stream_bytes.push_back(PrefixOpen);
			stream_bytes.push_back(t);
			stream_bytes.push_back(PrefixClose);
		end else
			stream_bytes.push_back(t);
	endfunction

	function automatic void put_int(logic [7:0] t, logic [63:0] v);
		int size;
		size = int_size(t);
		for (int i = 0; i < size; i++)
			stream_bytes.push_back(is_little(t) ? v[8 * i +: 8] : v[8 * (size - 1 - i) +: 8]);
	endfunction

	function automatic void put_item_int(logic [7:0] t, logic [63:0] v, bit tagged_item);
		put_header(t, tagged_item);
		put_int(t, v);
	endfunction

	// A count type of TypeNil selects the one-byte count form.
	function automatic void put_string(int len, logic [7:0] count_type, bit tagged_item);
		put_header(TypeString, tagged_item);
		if (count_type == TypeNil)
			stream_bytes.push_back(8'(len));
		else begin
			stream_bytes.push_back({1'b1, count_type[6:0]});
			put_int(count_type, 64'(len));
		end
		repeat (len) stream_bytes.push_back(8'($urandom));
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int          pick;
		int          len;
		int          w;
		int          burst_left;
		int          gap;
		bit          tagged_item;
		logic [7:0]  t;
		logic [7:0]  s;
		logic [63:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		burst_left = 0;

		put_header(TypeNil, 1'b0);
		put_header(TypeNil, 1'b1);
		put_item_int(TypeI16Le, 64'h7FFF, 1'b0);
		put_item_int(TypeI16Le, 64'h8000, 1'b0);
		put_item_int(TypeI16Be, 64'hFFFF, 1'b1);
		put_item_int(TypeI16Be, 64'h0000, 1'b0);
		put_item_int(TypeI32Le, 64'h7FFF_FFFF, 1'b0);
		put_item_int(TypeI32Be, 64'h8000_0000, 1'b0);
		put_item_int(TypeI32Le, 64'hFFFF_FFFF, 1'b1);
		put_item_int(TypeI64Le, 64'h8000_0000_0000_0000, 1'b0);
		put_item_int(TypeI64Be, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		put_item_int(TypeI64Be, 64'h0123_4567_89AB_CDEF, 1'b1);
		put_item_int(TypeI64Le, 64'h0123_4567_89AB_CDEF, 1'b0);
		put_string(0, TypeNil, 1'b0);
		put_string(1, TypeNil, 1'b0);
		put_string(127, TypeNil, 1'b1);
		put_string(3, TypeI16Le, 1'b0);
		put_string(0, TypeI16Be, 1'b0);
		put_string(2, TypeI32Le, 1'b1);
		put_string(1, TypeI32Be, 1'b0);
		put_string(4, TypeI64Le, 1'b0);
		put_string(0, TypeI64Be, 1'b0);

		while (stream_bytes.size() < StreamTarget) begin
			tagged_item = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 10)
				put_header(TypeNil, tagged_item);
			else if (pick < 45) begin
				t = int_type_at($urandom_range(0, 5));
				w = 8 * int_size(t);
				case ($urandom_range(0, 3))
					0: v = $urandom_range(0, 1) ? (64'd1 << (w - 1)) : ((64'd1 << (w - 1)) - 1);
					1: v = {64{$urandom_range(0, 1) == 1}};
					2: begin
						s = 8'($urandom);
						v = {{56{s[7]}}, s};
					end
					default: v = {$urandom, $urandom};
				endcase
				put_item_int(t, v, tagged_item);
			end else begin
				len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
				if (pick < 75)
					put_string(len, TypeNil, tagged_item);
				else
					put_string(len, int_type_at($urandom_range(0, 5)), tagged_item);
			end
		end

		// Every error halts the block for good and a saturated count never ends its
		// string, so the stream ends in one of them, followed by words that give either
		// no token or only string bytes.
		case ($urandom_range(0, 4))
			0: begin
				put_header(TypeString, 1'b0);
				stream_bytes.push_back({1'b1, non_int_type()});
			end
			1: begin
				case ($urandom_range(0, 2))
					0: stream_bytes.push_back(8'($urandom_range(8'h81, 8'hFF)));
					1: begin
						do
							t = {1'b0, non_int_type()};
						while (t == TypeNil || t == TypeString);
						stream_bytes.push_back(t);
					end
					default: put_header(PrefixOpen, 1'b1);
				endcase
			end
			2: begin
				stream_bytes.push_back(PrefixOpen);
				stream_bytes.push_back(8'($urandom));
				do
					t = 8'($urandom);
				while (t == PrefixClose);
				stream_bytes.push_back(t);
			end
			3: begin
				t = int_type_at($urandom_range(0, 5));
				w = 8 * int_size(t);
				v = {$urandom, $urandom} | (64'd1 << (w - 1));
				put_header(TypeString, 1'b0);
				stream_bytes.push_back({1'b1, t[6:0]});
				put_int(t, v);
			end
			default: begin
				t = int_type_at($urandom_range(4, 5));
				v = {$urandom, $urandom};
				v[63] = 1'b0;
				v[32 + $urandom_range(0, 30)] = 1'b1;
				put_header(TypeString, 1'b0);
				stream_bytes.push_back({1'b1, t[6:0]});
				put_int(t, v);
			end
		endcase
		repeat (30) stream_bytes.push_back(8'($urandom));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (stream_bytes.size() > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			in_valid <= 1'b1;
			data_byte <= stream_bytes.pop_front();
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			burst_left--;
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (tokens_pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tagged_binary_value_tokenizer: match");
		else
			$display("tagged_binary_value_tokenizer: mismatch");
		$finish;
	end

	// The token side stalls on patterns of its own and, twice, holds off long enough
	// for the block to fill up and stop taking words.
	initial begin
		int rx_cycle;
		int ready_mode;
		int mode_left;
		out_ready = 1'b0;
		rx_cycle = 0;
		ready_mode = 0;
		mode_left = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == 600 || rx_cycle == 2400) begin
				out_ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
			end
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (ready_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (rx_cycle % 4) != 0;
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles == IdleLimit) begin
			$display("tagged_binary_value_tokenizer: mismatch");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule

// ===== filelist.f =====
hdl/tbvt_pkg.sv
hdl/tbvt_front.sv
hdl/tbvt_queue.sv
hdl/tbvt_back.sv
hdl/tagged_binary_value_tokenizer.sv
hdl/tbvt_checker.sv
tb/tbvt_token_checker.sv
tb/testbench.sv
